// ----- rtl/core/sssu_pkg.sv -----
// shared types and constants for the 3x3 shift search sad unit
package sssu_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int SUM_BITS   = 40;
  localparam int OUT_W      = 40;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 12;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int N_SUMS     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] RESET_W    = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_H    = SIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_MASK_ENABLE  = 2'd2,
    CFG_MASK_INDEX   = 2'd3
  } sssu_cfg_idx_t;

  typedef logic [PIX_W-1:0]    sssu_pix_t;
  typedef logic [SUM_BITS-1:0] sssu_sum_t;
  typedef logic [OUT_W-1:0]    sssu_out_t;
  typedef logic [COL_W-1:0]    sssu_col_t;
  typedef logic [ROW_W-1:0]    sssu_row_t;
  typedef logic [SIZE_W-1:0]   sssu_size_t;
  typedef logic [N_SUMS-1:0][SUM_BITS-1:0] sssu_sums_t;

  // one column of the line store: two background rows, current pixel, include bit
  typedef struct packed {
    sssu_pix_t bg1;
    sssu_pix_t bg0;
    sssu_pix_t cur;
    logic      inc;
  } sssu_line_t;

  localparam int LINE_W = $bits(sssu_line_t);

  typedef struct packed {
    logic valid;
    logic interior;
    logic frame_end;
  } sssu_ctrl_t;

  function automatic sssu_size_t sssu_clamp(input sssu_size_t v, input sssu_size_t hi);
    sssu_size_t res;
    if (v < MIN_SIZE) begin
      res = MIN_SIZE;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/sssu_line_store.sv -----
// line store memory for background rows, current row and include bits
module sssu_line_store (
  input  logic                     clk,
  input  logic                     wr_en,
  input  sssu_pkg::sssu_col_t      wr_addr,
  input  sssu_pkg::sssu_line_t     wr_data,
  input  logic                     rd_en,
  input  sssu_pkg::sssu_col_t      rd_addr,
  output sssu_pkg::sssu_line_t     rd_data
);
  import sssu_pkg::*;

  sssu_line_t mem [MAX_WIDTH];
  sssu_line_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/sssu_sad_datapath.sv -----
// 3x3 background window, absolute differences and the nine accumulators
module sssu_sad_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sssu_pkg::sssu_ctrl_t   ctrl,
  input  sssu_pkg::sssu_pix_t    bg_pixel,
  input  sssu_pkg::sssu_line_t   rd_line,
  output sssu_pkg::sssu_sums_t   sums
);
  import sssu_pkg::*;

  logic [2:0][2:0][PIX_W-1:0] win_r, win_nxt;
  sssu_pix_t  held_cur_r;
  logic       held_inc_r;
  sssu_sums_t acc_r, acc_nxt, sum_tot;
  logic       add_en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = rd_line.bg1;
    win_nxt[1][2] = rd_line.bg0;
    win_nxt[2][2] = bg_pixel;
  end

  assign add_en = ctrl.interior && held_inc_r;

  always_comb begin
    sssu_pix_t b;
    sssu_pix_t d;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        b = win_nxt[i][j];
        d = (held_cur_r > b) ? sssu_pix_t'(held_cur_r - b) : sssu_pix_t'(b - held_cur_r);
        sum_tot[i*3+j] = acc_r[i*3+j] + (add_en ? SUM_BITS'(d) : '0);
        acc_nxt[i*3+j] = ctrl.frame_end ? '0 : sum_tot[i*3+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      held_inc_r <= 1'b0;
    end else if (ctrl.valid) begin
      acc_r      <= acc_nxt;
      held_inc_r <= rd_line.inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      win_r      <= win_nxt;
      held_cur_r <= rd_line.cur;
    end
  end

  assign sums = sum_tot;

endmodule

// ----- rtl/core/sad_3x3_shift_search_unit.sv -----
// top level of the 3x3 shift search sad unit
// a frame's result is valid once its last pixel request has passed the s1 register and the result register
// throughput: one pixel request per cycle while in_ready is high, set by one line store read and one write per cycle
// the last pixel of a frame waits while the previous frame's result is not yet taken
// reset: synchronous active-low; clears raster position, sums and valid flags, and loads the config defaults
// the line store needs no clearing pass and is not cleared
module sad_3x3_shift_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sssu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sssu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_cur_pixel,
  input  logic [7:0]                    in_bg_pixel,
  input  logic [7:0]                    in_mask_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [39:0]                   out_sum_up_left,
  output logic [39:0]                   out_sum_up,
  output logic [39:0]                   out_sum_up_right,
  output logic [39:0]                   out_sum_left,
  output logic [39:0]                   out_sum_centre,
  output logic [39:0]                   out_sum_right,
  output logic [39:0]                   out_sum_down_left,
  output logic [39:0]                   out_sum_down,
  output logic [39:0]                   out_sum_down_right
);
  import sssu_pkg::*;

  sssu_size_t width_r, height_r;
  logic       mask_en_r;
  sssu_pix_t  mask_idx_r;

  sssu_col_t  col_r;
  sssu_row_t  row_r;
  logic       last_col, last_row, frame_end_now, in_fire, inc_now;

  sssu_ctrl_t s1_ctrl_r;
  sssu_col_t  s1_addr_r;
  sssu_pix_t  s1_cur_r, s1_bg_r;
  logic       s1_inc_r;

  sssu_line_t rd_line, wr_line;
  sssu_sums_t sums;

  logic       out_valid_r;
  logic [N_SUMS-1:0][OUT_W-1:0] out_sums_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RESET_W;
      height_r   <= RESET_H;
      mask_en_r  <= 1'b0;
      mask_idx_r <= '0;
    end else if (cfg_valid) begin
      unique case (sssu_cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r    <= sssu_clamp(cfg_data[SIZE_W-1:0], MAX_W_SIZE);
        CFG_IMAGE_HEIGHT: height_r   <= sssu_clamp(cfg_data[SIZE_W-1:0], MAX_H_SIZE);
        CFG_MASK_ENABLE:  mask_en_r  <= cfg_data[0];
        CFG_MASK_INDEX:   mask_idx_r <= cfg_data[PIX_W-1:0];
        default:          mask_idx_r <= mask_idx_r;
      endcase
    end
  end

  assign last_col      = (SIZE_W'(col_r) + SIZE_W'(1)) >= width_r;
  assign last_row      = (SIZE_W'(row_r) + SIZE_W'(1)) >= height_r;
  assign frame_end_now = last_col && last_row;
  assign in_ready      = !(frame_end_now && out_valid_r);
  assign in_fire       = in_valid && in_ready;
  assign inc_now       = !mask_en_r || (in_mask_pixel == mask_idx_r);

  // raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else begin
      s1_ctrl_r.valid     <= in_fire;
      s1_ctrl_r.interior  <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_ctrl_r.frame_end <= frame_end_now;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= col_r;
      s1_cur_r  <= in_cur_pixel;
      s1_bg_r   <= in_bg_pixel;
      s1_inc_r  <= inc_now;
    end
  end

  always_comb begin
    wr_line.bg1 = rd_line.bg0;
    wr_line.bg0 = s1_bg_r;
    wr_line.cur = s1_cur_r;
    wr_line.inc = s1_inc_r;
  end

  sssu_line_store u_line_store (
    .clk     (clk),
    .wr_en   (s1_ctrl_r.valid),
    .wr_addr (s1_addr_r),
    .wr_data (wr_line),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (rd_line)
  );

  sssu_sad_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (s1_ctrl_r),
    .bg_pixel (s1_bg_r),
    .rd_line  (rd_line),
    .sums     (sums)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (s1_ctrl_r.valid && s1_ctrl_r.frame_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctrl_r.valid && s1_ctrl_r.frame_end) begin
      for (int k = 0; k < N_SUMS; k++) begin
        out_sums_r[k] <= OUT_W'(sums[k]);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sum_up_left    = out_sums_r[0];
  assign out_sum_up         = out_sums_r[1];
  assign out_sum_up_right   = out_sums_r[2];
  assign out_sum_left       = out_sums_r[3];
  assign out_sum_centre     = out_sums_r[4];
  assign out_sum_right      = out_sums_r[5];
  assign out_sum_down_left  = out_sums_r[6];
  assign out_sum_down       = out_sums_r[7];
  assign out_sum_down_right = out_sums_r[8];

endmodule
